// ----- rtl/core/pps_pkg.sv -----
// shared types and constants for the packetizer with pair-swapped checksum
// used by every module in rtl/core; depends on nothing
`default_nettype none

package pps_pkg;

   localparam int MAX_PAYLOAD = 1024;
   localparam int BYTE_W      = 8;
   localparam int INDEX_W     = 10;
   localparam int LIMIT_W     = 11;
   localparam int SUM_W       = 32;

   localparam logic [LIMIT_W-1:0] MAX_LIMIT   = LIMIT_W'(MAX_PAYLOAD);
   localparam logic [LIMIT_W-1:0] RESET_LIMIT = LIMIT_W'(1024);
   localparam logic [LIMIT_W-1:0] MIN_LIMIT   = LIMIT_W'(1);

   localparam logic KIND_DATA      = 1'b0;
   localparam logic KIND_LAST_DATA = 1'b1;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              message_last;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]       out_byte;
      logic [INDEX_W-1:0]      byte_index;
      logic                    packet_end;
      logic                    packet_kind;
      logic [LIMIT_W-1:0]      packet_length;
      logic signed [SUM_W-1:0] packet_checksum;
   } rsp_type;

   typedef struct packed {
      logic               advance;
      logic [INDEX_W-1:0] pos;
      logic               odd;
      logic               packet_end;
   } ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/core/pps_frame.sv -----
// framing control: payload limit register, byte position counter, end of packet
// depends on pps_pkg
`default_nettype none

module pps_frame
   import pps_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               message_last,
   input  wire logic               csr_write_enable,
   input  wire logic [LIMIT_W-1:0] csr_write_data,
   output ctrl_type                ctrl
);

   logic [LIMIT_W-1:0] limit_ff;
   logic [INDEX_W-1:0] position_ff, position_in;
   logic [LIMIT_W-1:0] eff_limit;
   logic [LIMIT_W-1:0] next_count;
   logic               end_flag;

   always_comb begin
      eff_limit = limit_ff;
      if (limit_ff == '0) begin
         eff_limit = MIN_LIMIT;
      end else if (limit_ff > MAX_LIMIT) begin
         eff_limit = MAX_LIMIT;
      end
      next_count = {1'b0, position_ff} + LIMIT_W'(1);
      end_flag   = message_last || (next_count >= eff_limit);
      position_in = position_ff;
      if (advance) begin
         position_in = end_flag ? '0 : next_count[INDEX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= RESET_LIMIT;
         position_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         position_ff <= position_in;
      end
   end

   assign ctrl.advance    = advance;
   assign ctrl.pos        = position_ff;
   assign ctrl.odd        = position_ff[0];
   assign ctrl.packet_end = end_flag;

endmodule

`default_nettype wire

// ----- rtl/core/pps_checksum.sv -----
// pair-swapped position-weighted checksum: held even byte and running sum
// depends on pps_pkg and the control from pps_frame
`default_nettype none

module pps_checksum
   import pps_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctrl_type          ctrl,
   input  wire logic [BYTE_W-1:0] data_byte,
   output logic signed [SUM_W-1:0] packet_checksum
);

   logic [BYTE_W-1:0]       held_ff, held_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [BYTE_W:0]  operand;
   logic signed [LIMIT_W-1:0] pos_s;
   logic signed [BYTE_W+LIMIT_W:0] product;
   logic signed [SUM_W-1:0] weighted;
   logic signed [SUM_W-1:0] sum_next;

   // odd: held*pos + b*(pos-1) = (held+b)*pos - b
   always_comb begin
      if (ctrl.odd) begin
         operand = $signed({held_ff[BYTE_W-1], held_ff})
                 + $signed({data_byte[BYTE_W-1], data_byte});
      end else begin
         operand = $signed({data_byte[BYTE_W-1], data_byte});
      end
      pos_s    = $signed({1'b0, ctrl.pos});
      product  = operand * pos_s;
      weighted = SUM_W'(product);
      if (ctrl.odd) begin
         weighted = weighted - SUM_W'($signed(data_byte));
      end
      sum_next = sum_ff + weighted;

      sum_in  = sum_ff;
      held_in = held_ff;
      if (ctrl.advance) begin
         if (ctrl.packet_end) begin
            sum_in  = '0;
            held_in = '0;
         end else if (ctrl.odd) begin
            sum_in = sum_next;
         end else begin
            held_in = data_byte;
         end
      end
      packet_checksum = ctrl.packet_end ? sum_next : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         sum_ff  <= '0;
      end else begin
         held_ff <= held_in;
         sum_ff  <= sum_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/packetizer_pair_swap_checksum.sv -----
// packetizer with pair-swapped checksum: block top level
// Usage:
//   req channel (req_valid/req_ready/req_data) takes one message byte per item
//   with its message_last flag. rsp channel (rsp_valid/rsp_ready/rsp_data)
//   gives exactly one item per input byte: the byte, its index in the packet,
//   and on the closing byte the packet kind, length and 32-bit checksum.
//   csr_write_enable/csr_write_data write payload_limit (0 acts as 1, values
//   above 1024 act as 1024); write only while the block is idle.
// Path: an accepted byte enters the input register, which feeds the result register
//   driving rsp_valid; the checksum is one 9x11 multiply, a 32-bit subtract and add.
// Throughput: one item per cycle, sustained, while rsp_ready stays high.
// Reset: synchronous; clears both registers' valid, position, held byte and
//   running sum, and sets payload_limit to 1024.
// Stall: while rsp_ready is low the result holds; the input register still
//   takes one more item, then req_ready falls until the result is taken.
// depends on pps_pkg, pps_frame, pps_checksum
`default_nettype none

module packetizer_pair_swap_checksum
   import pps_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_data,
   input  wire logic               csr_write_enable,
   input  wire logic [LIMIT_W-1:0] csr_write_data
);

   logic     in_valid_ff, in_valid_in;
   req_type  in_data_ff;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff, rsp_data_in;
   logic     out_open;
   logic     advance;
   logic     req_fire;
   ctrl_type ctrl;
   logic signed [SUM_W-1:0] checksum;

   assign out_open  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_open;
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   pps_frame u_frame (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .message_last     (in_data_ff.message_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .ctrl             (ctrl)
   );

   pps_checksum u_checksum (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .data_byte       (in_data_ff.data_byte),
      .packet_checksum (checksum)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      rsp_data_in.out_byte        = in_data_ff.data_byte;
      rsp_data_in.byte_index      = ctrl.pos;
      rsp_data_in.packet_end      = ctrl.packet_end;
      rsp_data_in.packet_kind     = (ctrl.packet_end && in_data_ff.message_last)
                                    ? KIND_LAST_DATA : KIND_DATA;
      rsp_data_in.packet_length   = ctrl.packet_end
                                    ? ({1'b0, ctrl.pos} + LIMIT_W'(1)) : '0;
      rsp_data_in.packet_checksum = checksum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/pps_checker.sv -----
// port-level checks for packetizer_pair_swap_checksum, bound to the top level
// depends on pps_pkg
`default_nettype none

module pps_checker
   import pps_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // result holds while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");

   // no result right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // packet fields are zero on bytes that do not close a packet
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.packet_end |->
         rsp_data.packet_length == '0 && rsp_data.packet_checksum == '0
         && rsp_data.packet_kind == KIND_DATA)
      else $error("packet fields set on a mid-packet item");

   // closing byte length follows its index
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.packet_end |->
         rsp_data.packet_length == ({1'b0, rsp_data.byte_index} + LIMIT_W'(1)))
      else $error("packet_length does not match byte_index");

   // an item taken under a stalled result fills the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && req_valid && req_ready |=> req_ready == rsp_ready)
      else $error("req_ready wrong while the result is stalled");

endmodule

bind packetizer_pair_swap_checksum pps_checker u_pps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- dv/frame_checker.sv -----
// scoreboard for the packetizer with pair-swapped checksum: watches both channels
// and the csr port, predicts every result item and compares it field by field
// depends on pps_pkg
module frame_checker
   import pps_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  req_type                 req_data,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  rsp_type                 rsp_data,
   input  wire logic               csr_write_enable,
   input  wire logic [LIMIT_W-1:0] csr_write_data,
   output int                      mismatch_count,
   output int                      frames_owed
);

   logic [LIMIT_W-1:0] limit_reg;
   logic [INDEX_W-1:0] cur_pos;
   logic [BYTE_W-1:0]  pending_even;
   logic [SUM_W-1:0]   pair_sum;
   rsp_type            expected_frames[$];
   rsp_type            want;

   function automatic logic [SUM_W-1:0] widen(input logic [BYTE_W-1:0] b);
      return {{(SUM_W-BYTE_W){b[BYTE_W-1]}}, b};
   endfunction

   // frames one byte and moves the packet state on
   function automatic rsp_type advance_frame(input req_type item);
      rsp_type          r;
      int               lim;
      logic [SUM_W-1:0] acc;
      logic             closes;
      lim = int'(limit_reg);
      if (limit_reg == '0) lim = 1;
      if (limit_reg > MAX_LIMIT) lim = MAX_PAYLOAD;
      closes = item.message_last || (int'(cur_pos) + 1 >= lim);
      acc = pair_sum;
      if (cur_pos[0]) begin
         acc = acc + widen(pending_even) * SUM_W'(cur_pos)
               + widen(item.data_byte) * SUM_W'(cur_pos - 1'b1);
      end else begin
         pending_even = item.data_byte;
         if (closes) acc = acc + widen(item.data_byte) * SUM_W'(cur_pos);
      end
      r.out_byte   = item.data_byte;
      r.byte_index = cur_pos;
      r.packet_end = closes;
      if (closes) begin
         r.packet_kind     = item.message_last ? KIND_LAST_DATA : KIND_DATA;
         r.packet_length   = LIMIT_W'(cur_pos) + 1'b1;
         r.packet_checksum = acc;
         cur_pos      = '0;
         pair_sum     = '0;
         pending_even = '0;
      end else begin
         r.packet_kind     = KIND_DATA;
         r.packet_length   = '0;
         r.packet_checksum = '0;
         if (cur_pos[0]) pair_sum = acc;
         cur_pos = cur_pos + 1'b1;
      end
      return r;
   endfunction

   task automatic check_field(input string field, input logic [SUM_W-1:0] want_v,
                              input logic [SUM_W-1:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s expected %0h actual %0h", $time, field, want_v, got_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         limit_reg    = RESET_LIMIT;
         cur_pos      = '0;
         pending_even = '0;
         pair_sum     = '0;
         expected_frames.delete();
         frames_owed <= 0;
      end else begin
         if (csr_write_enable) limit_reg = csr_write_data;
         if (req_valid && req_ready) expected_frames.push_back(advance_frame(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               $display("%0t: unexpected item expected none actual %h", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = expected_frames.pop_front();
               check_field("out_byte", SUM_W'(want.out_byte),
                           SUM_W'(rsp_data.out_byte));
               check_field("byte_index", SUM_W'(want.byte_index),
                           SUM_W'(rsp_data.byte_index));
               check_field("packet_end", SUM_W'(want.packet_end),
                           SUM_W'(rsp_data.packet_end));
               check_field("packet_kind", SUM_W'(want.packet_kind),
                           SUM_W'(rsp_data.packet_kind));
               check_field("packet_length", SUM_W'(want.packet_length),
                           SUM_W'(rsp_data.packet_length));
               check_field("packet_checksum", want.packet_checksum,
                           rsp_data.packet_checksum);
            end
         end
         frames_owed <= expected_frames.size();
      end
   end

endmodule

// ----- dv/tb.sv -----
// top of the packetizer testbench: clock, reset, byte stimulus, csr writes,
// receiver back-pressure, watchdog and verdict
// depends on pps_pkg, packetizer_pair_swap_checksum and frame_checker
module tb;
   import pps_pkg::*;

   localparam int STALL_CYCLES = 80;
   localparam int QUIET_LIMIT  = 2000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   req_type            req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   rsp_type            rsp_data;
   logic               csr_write_enable;
   logic [LIMIT_W-1:0] csr_write_data;
   int                 mismatch_count;
   int                 frames_owed;
   int                 req_idle_pct;
   int                 rsp_idle_pct;
   int                 quiet_cycles;
   int                 items_sent;
   bit                 stall_request;
   bit                 stall_done;

   packetizer_pair_swap_checksum dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   frame_checker watch (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .frames_owed      (frames_owed)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      rsp_ready <= 1'b0;
      stall_done = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_request && !stall_done) begin
            stall_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
      req_type item;
      item.data_byte    = b;
      item.message_last = last;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_owed != 0) @(posedge clock);
   endtask

   task automatic set_limit(input logic [LIMIT_W-1:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) push_byte(BYTE_W'($urandom_range(0, 255)), i == len - 1);
   endtask

   function automatic logic [LIMIT_W-1:0] pick_limit();
      case ($urandom_range(7))
         0:       return '0;
         1:       return MIN_LIMIT;
         2:       return '1;
         3:       return MAX_LIMIT;
         4:       return MAX_LIMIT + 1'b1;
         5:       return LIMIT_W'($urandom_range(2, 8));
         default: return LIMIT_W'($urandom_range(1, 40));
      endcase
   endfunction

   task automatic random_stretch(input int quota);
      int target;
      int pick;
      target = items_sent + quota;
      while (items_sent < target) begin
         if ($urandom_range(5) == 0) set_limit(pick_limit());
         pick = $urandom_range(99);
         if (pick < 70) begin
            send_message($urandom_range(1, 12));
         end else if (pick < 85) begin
            send_message($urandom_range(13, 48));
         end else begin
            repeat ($urandom_range(1, 10))
               push_byte(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_data         <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      req_idle_pct  = 0;
      rsp_idle_pct  = 0;
      stall_request = 1'b0;
      items_sent    = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // signed extremes, odd packet length
      push_byte(8'h80, 1'b0);
      push_byte(8'h7f, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h01, 1'b1);
      // zero limit acts as one
      set_limit('0);
      push_byte(8'h55, 1'b0);
      push_byte(8'haa, 1'b0);
      push_byte(8'h12, 1'b1);
      // full last packet
      set_limit(LIMIT_W'(4));
      push_byte(8'h01, 1'b0);
      push_byte(8'h02, 1'b0);
      push_byte(8'h03, 1'b0);
      push_byte(8'h04, 1'b1);
      // oversize limit, then lowered mid-packet
      set_limit('1);
      push_byte(8'hfe, 1'b0);
      push_byte(8'h03, 1'b0);
      push_byte(8'h81, 1'b0);
      set_limit(LIMIT_W'(2));
      push_byte(8'h40, 1'b0);
      push_byte(8'h7f, 1'b1);

      req_idle_pct = 24;
      rsp_idle_pct = 73;
      random_stretch(200);

      drain();
      req_idle_pct = 73;
      rsp_idle_pct = 24;
      random_stretch(200);

      drain();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      set_limit('1);
      stall_request = 1'b1;
      send_message(40);
      random_stretch(180);

      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && frames_owed == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
